// ----- src/eight_opcode_cpu_step_core_defines.svh -----
// Assertion macros used by the port-level checker of the step core.
`ifndef EIGHT_OPCODE_CPU_STEP_CORE_DEFINES_SVH
`define EIGHT_OPCODE_CPU_STEP_CORE_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge out of reset.
`define ECPU_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("ecpu: same-cycle check failed");

// Next-cycle implication, checked at every rising clock edge out of reset.
`define ECPU_ASSERT_NXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("ecpu: next-cycle check failed");

`endif

// ----- src/ecpu_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecpu_pkg
// Shared types and constants of the eight-opcode step core.
// ----------------------------------------------------------------------------
package ecpu_pkg;

    localparam int unsigned MEM_WORDS = 65536;
    localparam int unsigned MEM_AW    = $clog2(MEM_WORDS);
    localparam int unsigned REG_COUNT = 8;
    localparam int unsigned REG_AW    = $clog2(REG_COUNT);
    localparam int unsigned WORD_W    = 32;
    localparam int unsigned PORT_AW   = 16;
    localparam int unsigned OP_LSB    = 22;
    localparam int unsigned RA_LSB    = 19;
    localparam int unsigned RB_LSB    = 16;
    localparam int unsigned OFF_W     = 16;

    typedef logic [MEM_AW-1:0] t_mem_addr;
    typedef logic [REG_AW-1:0] t_reg_idx;
    typedef logic [WORD_W-1:0] t_word;

    typedef enum logic [1:0] {
        MODE_LOAD     = 2'd0,
        MODE_EXEC     = 2'd1,
        MODE_READ_MEM = 2'd2,
        MODE_READ_REG = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        OP_ADD  = 3'd0,
        OP_NOR  = 3'd1,
        OP_LW   = 3'd2,
        OP_SW   = 3'd3,
        OP_BEQ  = 3'd4,
        OP_JALR = 3'd5,
        OP_HALT = 3'd6,
        OP_NOOP = 3'd7
    } t_opcode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_EXEC,
        S_LOAD,
        S_DONE
    } t_state;

    typedef struct packed {
        logic      rd;
        logic      wr;
        t_mem_addr addr;
        t_word     wdata;
    } t_mem_req;

    typedef struct packed {
        logic     rd;
        t_reg_idx idx_a;
        t_reg_idx idx_b;
        logic     wr;
        t_reg_idx widx;
        t_word    wdata;
    } t_rf_req;

    typedef struct packed {
        logic [PORT_AW-1:0] pc_value;
        logic               halted;
        logic [2:0]         opcode_done;
        logic               reg_write;
        t_reg_idx           reg_index;
        t_word              reg_value;
        logic               mem_write;
        logic [PORT_AW-1:0] mem_address;
        t_word              mem_value;
        t_word              read_data;
        t_word              executed_count;
    } t_result;

endpackage

// ----- src/ecpu_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecpu_mem
// Single-port main memory with a registered read port.
// ----------------------------------------------------------------------------
module ecpu_mem (
    input  logic              i_clk,
    input  ecpu_pkg::t_mem_req i_req,
    output ecpu_pkg::t_word    o_rdata
);

    ecpu_pkg::t_word r_mem [ecpu_pkg::MEM_WORDS];
    ecpu_pkg::t_word r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.wr) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        if (i_req.rd) begin
            r_rdata <= r_mem[i_req.addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/ecpu_rf.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecpu_rf
// Register file with two registered read ports, one write port and
// per-entry valid bits so that unwritten registers read as zero.
// ----------------------------------------------------------------------------
module ecpu_rf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ecpu_pkg::t_rf_req i_req,
    output ecpu_pkg::t_word   o_rdata_a,
    output ecpu_pkg::t_word   o_rdata_b
);

    ecpu_pkg::t_word                  r_regs [ecpu_pkg::REG_COUNT];
    logic [ecpu_pkg::REG_COUNT-1:0]   r_valid;
    ecpu_pkg::t_word                  r_rdata_a;
    ecpu_pkg::t_word                  r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_req.wr) begin
            r_valid[i_req.widx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.wr) begin
            r_regs[i_req.widx] <= i_req.wdata;
        end
        if (i_req.rd) begin
            r_rdata_a <= r_valid[i_req.idx_a] ? r_regs[i_req.idx_a] : '0;
            r_rdata_b <= r_valid[i_req.idx_b] ? r_regs[i_req.idx_b] : '0;
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// ----- src/eight_opcode_cpu_step_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eight_opcode_cpu_step_core
// Step core of an eight-register, eight-opcode word-addressed machine.
// ----------------------------------------------------------------------------
// Each input request carries a mode, an address and a data word; it loads a
// memory word, executes one instruction, reads a memory word or reads a
// register. Every request produces exactly one result on the output channel.
// Both channels use valid and ready.
// A load or read request goes from idle straight to the done state.
// An executed instruction passes through fetch over the single memory port,
// register file read, execute, and for lw a second memory read, then done.
// The result register is loaded in the final cycle of each request.
// Execute requests after a halt go straight to done and change nothing.
// Reset clears the register file valid bits, pc, halt flag and instruction
// count; main memory holds no reset value and must be loaded before use.
// The output register lets the core take the next request while a result
// waits; if the receiver stalls, the following request waits in its final
// cycle until the output register is free.
// ----------------------------------------------------------------------------
module eight_opcode_cpu_step_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_mode,
    input  logic [15:0] i_address,
    input  logic [31:0] i_data_word,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_pc_value,
    output logic        o_halted,
    output logic [2:0]  o_opcode_done,
    output logic        o_reg_write,
    output logic [2:0]  o_reg_index,
    output logic [31:0] o_reg_value,
    output logic        o_mem_write,
    output logic [15:0] o_mem_address,
    output logic [31:0] o_mem_value,
    output logic [31:0] o_read_data,
    output logic [31:0] o_executed_count
);

    ecpu_pkg::t_state    r_state, n_state;
    ecpu_pkg::t_mode     r_mode, n_mode;
    ecpu_pkg::t_word     r_instr, n_instr;
    ecpu_pkg::t_mem_addr r_pc, n_pc;
    logic                r_halted, n_halted;
    ecpu_pkg::t_word     r_count, n_count;
    ecpu_pkg::t_result   r_res, n_res;
    ecpu_pkg::t_result   r_out, n_out;
    logic                r_out_valid, n_out_valid;

    ecpu_pkg::t_mem_req  mem_req;
    ecpu_pkg::t_word     mem_rdata;
    ecpu_pkg::t_rf_req   rf_req;
    ecpu_pkg::t_word     rf_a;
    ecpu_pkg::t_word     rf_b;

    ecpu_pkg::t_opcode   op;
    ecpu_pkg::t_reg_idx  idx_a;
    ecpu_pkg::t_reg_idx  idx_b;
    ecpu_pkg::t_reg_idx  idx_d;
    ecpu_pkg::t_word     offset;
    ecpu_pkg::t_mem_addr eff_addr;
    ecpu_pkg::t_mem_addr pc_next;
    ecpu_pkg::t_mem_addr pc_branch;
    ecpu_pkg::t_word     pc_plus1;

    ecpu_mem u_mem (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    ecpu_rf u_rf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (rf_req),
        .o_rdata_a (rf_a),
        .o_rdata_b (rf_b)
    );

    assign op        = ecpu_pkg::t_opcode'(r_instr[ecpu_pkg::OP_LSB +: 3]);
    assign idx_a     = r_instr[ecpu_pkg::RA_LSB +: ecpu_pkg::REG_AW];
    assign idx_b     = r_instr[ecpu_pkg::RB_LSB +: ecpu_pkg::REG_AW];
    assign idx_d     = r_instr[ecpu_pkg::REG_AW-1:0];
    assign offset    = {{(ecpu_pkg::WORD_W-ecpu_pkg::OFF_W){r_instr[ecpu_pkg::OFF_W-1]}},
                        r_instr[ecpu_pkg::OFF_W-1:0]};
    assign pc_plus1  = ecpu_pkg::WORD_W'(r_pc) + 32'd1;
    assign pc_next   = ecpu_pkg::t_mem_addr'(pc_plus1);
    assign pc_branch = ecpu_pkg::t_mem_addr'(pc_plus1 + offset);
    assign eff_addr  = ecpu_pkg::t_mem_addr'(rf_a + offset);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ecpu_pkg::S_IDLE;
            r_pc        <= '0;
            r_halted    <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pc        <= n_pc;
            r_halted    <= n_halted;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode  <= n_mode;
        r_instr <= n_instr;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_instr     = r_instr;
        n_pc        = r_pc;
        n_halted    = r_halted;
        n_count     = r_count;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_ready;
        mem_req     = '0;
        rf_req      = '0;
        o_ready     = (r_state == ecpu_pkg::S_IDLE);

        unique case (r_state)
            ecpu_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_mode  = ecpu_pkg::t_mode'(i_mode);
                    n_res   = '0;
                    n_state = ecpu_pkg::S_DONE;
                    unique case (ecpu_pkg::t_mode'(i_mode))
                        ecpu_pkg::MODE_LOAD: begin
                            mem_req.wr        = 1'b1;
                            mem_req.addr      = ecpu_pkg::t_mem_addr'(i_address);
                            mem_req.wdata     = i_data_word;
                            n_res.mem_write   = 1'b1;
                            n_res.mem_address = ecpu_pkg::PORT_AW'(
                                                    ecpu_pkg::t_mem_addr'(i_address));
                            n_res.mem_value   = i_data_word;
                        end
                        ecpu_pkg::MODE_EXEC: begin
                            if (!r_halted) begin
                                mem_req.rd   = 1'b1;
                                mem_req.addr = r_pc;
                                n_state      = ecpu_pkg::S_DECODE;
                            end
                        end
                        ecpu_pkg::MODE_READ_MEM: begin
                            mem_req.rd   = 1'b1;
                            mem_req.addr = ecpu_pkg::t_mem_addr'(i_address);
                        end
                        ecpu_pkg::MODE_READ_REG: begin
                            rf_req.rd    = 1'b1;
                            rf_req.idx_a = i_address[ecpu_pkg::REG_AW-1:0];
                        end
                        default: begin
                            n_state = ecpu_pkg::S_DONE;
                        end
                    endcase
                end
            end
            ecpu_pkg::S_DECODE: begin
                n_instr      = mem_rdata;
                rf_req.rd    = 1'b1;
                rf_req.idx_a = mem_rdata[ecpu_pkg::RA_LSB +: ecpu_pkg::REG_AW];
                rf_req.idx_b = mem_rdata[ecpu_pkg::RB_LSB +: ecpu_pkg::REG_AW];
                n_state      = ecpu_pkg::S_EXEC;
            end
            ecpu_pkg::S_EXEC: begin
                n_count           = r_count + 32'd1;
                n_res.opcode_done = op;
                n_pc              = pc_next;
                n_state           = ecpu_pkg::S_DONE;
                unique case (op) inside
                    ecpu_pkg::OP_ADD, ecpu_pkg::OP_NOR: begin
                        rf_req.wr       = 1'b1;
                        rf_req.widx     = idx_d;
                        rf_req.wdata    = (op == ecpu_pkg::OP_ADD) ? rf_a + rf_b
                                                                   : ~(rf_a | rf_b);
                        n_res.reg_write = 1'b1;
                        n_res.reg_index = idx_d;
                        n_res.reg_value = rf_req.wdata;
                    end
                    ecpu_pkg::OP_LW: begin
                        mem_req.rd   = 1'b1;
                        mem_req.addr = eff_addr;
                        n_state      = ecpu_pkg::S_LOAD;
                    end
                    ecpu_pkg::OP_SW: begin
                        mem_req.wr        = 1'b1;
                        mem_req.addr      = eff_addr;
                        mem_req.wdata     = rf_b;
                        n_res.mem_write   = 1'b1;
                        n_res.mem_address = ecpu_pkg::PORT_AW'(eff_addr);
                        n_res.mem_value   = rf_b;
                    end
                    ecpu_pkg::OP_BEQ: begin
                        if (rf_a == rf_b) begin
                            n_pc = pc_branch;
                        end
                    end
                    ecpu_pkg::OP_JALR: begin
                        rf_req.wr       = 1'b1;
                        rf_req.widx     = idx_b;
                        rf_req.wdata    = pc_plus1;
                        n_res.reg_write = 1'b1;
                        n_res.reg_index = idx_b;
                        n_res.reg_value = pc_plus1;
                        n_pc            = (idx_a == idx_b) ? pc_next
                                                           : ecpu_pkg::t_mem_addr'(rf_a);
                    end
                    ecpu_pkg::OP_HALT: begin
                        n_halted = 1'b1;
                    end
                    ecpu_pkg::OP_NOOP: begin
                        n_pc = pc_next;
                    end
                    default: begin
                        n_pc = pc_next;
                    end
                endcase
            end
            ecpu_pkg::S_LOAD: begin
                rf_req.wr       = 1'b1;
                rf_req.widx     = idx_b;
                rf_req.wdata    = mem_rdata;
                n_res.reg_write = 1'b1;
                n_res.reg_index = idx_b;
                n_res.reg_value = mem_rdata;
                n_state         = ecpu_pkg::S_DONE;
            end
            ecpu_pkg::S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_out                = r_res;
                    n_out.pc_value       = ecpu_pkg::PORT_AW'(r_pc);
                    n_out.halted         = r_halted;
                    n_out.executed_count = r_count;
                    if (r_mode == ecpu_pkg::MODE_READ_MEM) begin
                        n_out.read_data = mem_rdata;
                    end else if (r_mode == ecpu_pkg::MODE_READ_REG) begin
                        n_out.read_data = rf_a;
                    end else begin
                        n_out.read_data = '0;
                    end
                    n_out_valid = 1'b1;
                    n_state     = ecpu_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ecpu_pkg::S_IDLE;
            end
        endcase
    end

    assign o_valid          = r_out_valid;
    assign o_pc_value       = r_out.pc_value;
    assign o_halted         = r_out.halted;
    assign o_opcode_done    = r_out.opcode_done;
    assign o_reg_write      = r_out.reg_write;
    assign o_reg_index      = r_out.reg_index;
    assign o_reg_value      = r_out.reg_value;
    assign o_mem_write      = r_out.mem_write;
    assign o_mem_address    = r_out.mem_address;
    assign o_mem_value      = r_out.mem_value;
    assign o_read_data      = r_out.read_data;
    assign o_executed_count = r_out.executed_count;

endmodule

// ----- src/ecpu_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecpu_checker
// Port-level checks of the step core, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "eight_opcode_cpu_step_core_defines.svh"

module ecpu_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic        o_halted,
    input logic        o_reg_write,
    input logic        o_mem_write,
    input logic [15:0] o_pc_value,
    input logic [31:0] o_executed_count
);

    `ECPU_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid)
    `ECPU_ASSERT_NXT(a_out_stable, i_clk, i_rst_n, o_valid && !i_ready, $stable(o_pc_value) && $stable(o_executed_count))
    `ECPU_ASSERT_NXT(a_halt_sticky, i_clk, i_rst_n, o_valid && i_ready && o_halted, !o_valid || o_halted)
    `ECPU_ASSERT_IMP(a_single_write, i_clk, i_rst_n, o_valid, !(o_reg_write && o_mem_write))

endmodule

bind eight_opcode_cpu_step_core ecpu_checker u_ecpu_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_valid          (o_valid),
    .i_ready          (i_ready),
    .o_halted         (o_halted),
    .o_reg_write      (o_reg_write),
    .o_mem_write      (o_mem_write),
    .o_pc_value       (o_pc_value),
    .o_executed_count (o_executed_count)
);

// ----- tb/eight_opcode_cpu_step_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eight_opcode_cpu_step_checker
// Result predictor and scoreboard for the eight-opcode step core.
// ----------------------------------------------------------------------------
// Keeps its own image of memory, registers, pc, halt flag and instruction
// count. Every accepted request advances that image and queues the result it
// implies. Every accepted result is compared field by field with the oldest
// queued one. The predicted pc, registers and halt flag are exported so that
// the stimulus can keep execution inside written memory.
// ----------------------------------------------------------------------------
module eight_opcode_cpu_step_checker
    import ecpu_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    input  logic             i_req_ready,
    input  logic [1:0]       i_mode,
    input  logic [15:0]      i_address,
    input  logic [31:0]      i_data_word,
    input  logic             i_rsp_valid,
    input  logic             i_rsp_ready,
    input  t_result          i_result,
    output int               o_fail_count,
    output int               o_outstanding,
    output logic [15:0]      o_pc,
    output logic [7:0][31:0] o_regs,
    output logic             o_halted
);

    bit   [31:0]      mem_image [0:MEM_WORDS-1];
    logic [7:0][31:0] reg_image  = '0;
    logic [15:0]      pc_state   = '0;
    logic             halt_state = 1'b0;
    logic [31:0]      exec_count = '0;
    t_result          step_outcomes [$];

    initial begin
        o_fail_count  = 0;
        o_outstanding = 0;
    end

    assign o_pc     = pc_state;
    assign o_regs   = reg_image;
    assign o_halted = halt_state;

    task automatic advance_machine(input t_mode mode, input logic [15:0] addr,
                                   input logic [31:0] data, output t_result res);
        logic [31:0] instr;
        t_opcode     op;
        t_reg_idx    ra;
        t_reg_idx    rb;
        logic [31:0] offset;
        logic [15:0] next_pc;
        res = '0;
        case (mode)
            MODE_LOAD: begin
                mem_image[addr] = data;
                res.mem_write   = 1'b1;
                res.mem_address = addr;
                res.mem_value   = data;
            end
            MODE_READ_MEM: res.read_data = mem_image[addr];
            MODE_READ_REG: res.read_data = reg_image[addr[2:0]];
            default: begin
                if (!halt_state) begin
                    instr   = mem_image[pc_state];
                    op      = t_opcode'(instr[24:22]);
                    ra      = instr[21:19];
                    rb      = instr[18:16];
                    offset  = {{16{instr[15]}}, instr[15:0]};
                    next_pc = pc_state + 16'd1;
                    exec_count      = exec_count + 32'd1;
                    res.opcode_done = op;
                    case (op)
                        OP_ADD, OP_NOR: begin
                            res.reg_value = (op == OP_ADD) ? reg_image[ra] + reg_image[rb]
                                                           : ~(reg_image[ra] | reg_image[rb]);
                            reg_image[instr[2:0]] = res.reg_value;
                            res.reg_write = 1'b1;
                            res.reg_index = instr[2:0];
                            pc_state      = next_pc;
                        end
                        OP_LW: begin
                            res.reg_value = mem_image[16'(reg_image[ra] + offset)];
                            reg_image[rb] = res.reg_value;
                            res.reg_write = 1'b1;
                            res.reg_index = rb;
                            pc_state      = next_pc;
                        end
                        OP_SW: begin
                            res.mem_write   = 1'b1;
                            res.mem_address = 16'(reg_image[ra] + offset);
                            res.mem_value   = reg_image[rb];
                            mem_image[res.mem_address] = res.mem_value;
                            pc_state        = next_pc;
                        end
                        OP_BEQ: begin
                            if (reg_image[ra] == reg_image[rb]) begin
                                pc_state = next_pc + offset[15:0];
                            end else begin
                                pc_state = next_pc;
                            end
                        end
                        OP_JALR: begin
                            res.reg_value = 32'(pc_state) + 32'd1;
                            reg_image[rb] = res.reg_value;
                            res.reg_write = 1'b1;
                            res.reg_index = rb;
                            pc_state      = reg_image[ra][15:0];
                        end
                        OP_HALT: begin
                            halt_state = 1'b1;
                            pc_state   = next_pc;
                        end
                        default: pc_state = next_pc;
                    endcase
                end
            end
        endcase
        res.pc_value       = pc_state;
        res.halted         = halt_state;
        res.executed_count = exec_count;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            if (o_fail_count < 10) begin
                $display("checker: %s mismatch, expected %h, actual %h", name, want, got);
            end
            o_fail_count++;
        end
    endtask

    task automatic compare_outcome(input t_result got);
        t_result want;
        if (step_outcomes.size() == 0) begin
            if (o_fail_count < 10) begin
                $display("checker: result arrived with no request outstanding");
            end
            o_fail_count++;
        end else begin
            want = step_outcomes.pop_front();
            check_field("pc_value", want.pc_value, got.pc_value);
            check_field("halted", want.halted, got.halted);
            check_field("opcode_done", want.opcode_done, got.opcode_done);
            check_field("reg_write", want.reg_write, got.reg_write);
            check_field("reg_index", want.reg_index, got.reg_index);
            check_field("reg_value", want.reg_value, got.reg_value);
            check_field("mem_write", want.mem_write, got.mem_write);
            check_field("mem_address", want.mem_address, got.mem_address);
            check_field("mem_value", want.mem_value, got.mem_value);
            check_field("read_data", want.read_data, got.read_data);
            check_field("executed_count", want.executed_count, got.executed_count);
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_result predicted;
        if (i_rst_n) begin
            if (i_rsp_valid && i_rsp_ready) begin
                compare_outcome(i_result);
            end
            if (i_req_valid && i_req_ready) begin
                advance_machine(t_mode'(i_mode), i_address, i_data_word, predicted);
                step_outcomes.push_back(predicted);
            end
            o_outstanding = step_outcomes.size();
        end
    end

endmodule

// ----- tb/eight_opcode_cpu_step_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eight_opcode_cpu_step_core_tb
// Top-level testbench for the eight-opcode step core.
// ----------------------------------------------------------------------------
// Runs a short hand-built program that touches every opcode but halt, address
// and pc wrap and jalr with equal registers, then several hundred random requests
// in which execution is steered so that every fetch and every lw hits a word
// already written. The run ends with a halt, execute requests after it and
// loads and reads while halted. Both channels idle at random, except over
// one long stretch. The checker predicts and compares all results.
// ----------------------------------------------------------------------------
module eight_opcode_cpu_step_core_tb;
    import ecpu_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int RANDOM_REQUESTS = 700;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        req_valid   = 1'b0;
    logic        req_ready;
    t_mode       req_mode    = MODE_READ_REG;
    logic [15:0] req_address = '0;
    logic [31:0] req_data    = '0;
    logic        rsp_valid;
    logic        rsp_ready   = 1'b0;
    logic [15:0] pc_value;
    logic        halted;
    logic [2:0]  opcode_done;
    logic        reg_write;
    logic [2:0]  reg_index;
    logic [31:0] reg_value;
    logic        mem_write;
    logic [15:0] mem_address;
    logic [31:0] mem_value;
    logic [31:0] read_data;
    logic [31:0] executed_count;
    t_result     dut_result;

    int               fail_count;
    int               outstanding;
    logic [15:0]      model_pc;
    logic [7:0][31:0] model_regs;
    logic             model_halted;

    bit               quiet_stretch = 1'b0;
    int               cycle_count   = 0;
    bit   [31:0]      shadow_word  [0:MEM_WORDS-1];
    bit               shadow_known [0:MEM_WORDS-1];
    logic [15:0]      written_list [$];

    assign dut_result = {pc_value, halted, opcode_done, reg_write, reg_index, reg_value,
                         mem_write, mem_address, mem_value, read_data, executed_count};

    eight_opcode_cpu_step_core i_dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_valid          (req_valid),
        .o_ready          (req_ready),
        .i_mode           (req_mode),
        .i_address        (req_address),
        .i_data_word      (req_data),
        .o_valid          (rsp_valid),
        .i_ready          (rsp_ready),
        .o_pc_value       (pc_value),
        .o_halted         (halted),
        .o_opcode_done    (opcode_done),
        .o_reg_write      (reg_write),
        .o_reg_index      (reg_index),
        .o_reg_value      (reg_value),
        .o_mem_write      (mem_write),
        .o_mem_address    (mem_address),
        .o_mem_value      (mem_value),
        .o_read_data      (read_data),
        .o_executed_count (executed_count)
    );

    eight_opcode_cpu_step_checker i_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_req_valid   (req_valid),
        .i_req_ready   (req_ready),
        .i_mode        (req_mode),
        .i_address     (req_address),
        .i_data_word   (req_data),
        .i_rsp_valid   (rsp_valid),
        .i_rsp_ready   (rsp_ready),
        .i_result      (dut_result),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding),
        .o_pc          (model_pc),
        .o_regs        (model_regs),
        .o_halted      (model_halted)
    );

    always #6 clk = ~clk;

    always @(negedge clk) begin
        rsp_ready <= quiet_stretch || ($urandom_range(99) >= 17);
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send_request(input t_mode mode, input logic [15:0] addr,
                                input logic [31:0] data);
        while (!quiet_stretch && $urandom_range(99) < 17) begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid   <= 1'b1;
        req_mode    <= mode;
        req_address <= addr;
        req_data    <= data;
        @(posedge clk);
        while (!req_ready) begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task automatic load_word(input logic [15:0] addr, input logic [31:0] data);
        if (!shadow_known[addr]) begin
            written_list.push_back(addr);
        end
        shadow_known[addr] = 1'b1;
        shadow_word[addr]  = data;
        send_request(MODE_LOAD, addr, data);
    endtask

    task automatic exec_step();
        logic [31:0] instr;
        logic [15:0] target;
        instr = shadow_word[model_pc];
        if (!model_halted && instr[24:22] == OP_SW) begin
            target = model_regs[instr[21:19]][15:0] + instr[15:0];
            if (!shadow_known[target]) begin
                written_list.push_back(target);
            end
            shadow_known[target] = 1'b1;
            shadow_word[target]  = model_regs[instr[18:16]];
        end
        send_request(MODE_EXEC, 16'($urandom), $urandom);
    endtask

    task automatic random_exec();
        logic [31:0] instr;
        t_opcode     op;
        logic [2:0]  ra;
        logic [15:0] low;
        int          pick;
        bit          usable;
        instr  = shadow_word[model_pc];
        ra     = instr[21:19];
        usable = shadow_known[model_pc] && instr[24:22] != OP_HALT;
        if (instr[24:22] == OP_LW) begin
            usable = usable && shadow_known[16'(model_regs[ra][15:0] + instr[15:0])];
        end
        if (!usable || $urandom_range(99) < 35) begin
            pick = $urandom_range(99);
            op   = (pick < 18) ? OP_ADD : (pick < 32) ? OP_NOR : (pick < 50) ? OP_LW :
                   (pick < 66) ? OP_SW : (pick < 82) ? OP_BEQ : (pick < 90) ? OP_JALR :
                   OP_NOOP;
            ra   = 3'($urandom);
            low  = 16'($urandom);
            if (op == OP_LW) begin
                low = written_list[$urandom_range(written_list.size() - 1)]
                      - model_regs[ra][15:0];
            end else if (op == OP_BEQ && $urandom_range(1) == 1) begin
                low = 16'(int'($urandom_range(16)) - 8);
            end
            load_word(model_pc, {7'($urandom), op, ra, 3'($urandom), low});
        end
        exec_step();
    endtask

    function automatic logic [31:0] encode(input t_opcode op, input logic [2:0] ra,
                                           input logic [2:0] rb, input logic [15:0] low);
        return {7'h00, op, ra, rb, low};
    endfunction

    initial begin : stimulus
        int pick;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        load_word(16'hFFFF, 32'hFFFF_FFFF);
        load_word(16'd0, encode(OP_NOR, 3'd0, 3'd0, 16'h0001));
        load_word(16'd1, encode(OP_ADD, 3'd1, 3'd1, 16'hFFFA));
        load_word(16'd2, encode(OP_LW, 3'd1, 3'd3, 16'h0001));
        load_word(16'd3, encode(OP_SW, 3'd2, 3'd1, 16'h7FFF));
        load_word(16'd4, encode(OP_BEQ, 3'd1, 3'd2, 16'h8000));
        load_word(16'd5, encode(OP_JALR, 3'd4, 3'd4, 16'h0000));
        load_word(16'd6, {7'h55, OP_NOOP, 22'h2AAAAA});
        load_word(16'd7, encode(OP_BEQ, 3'd0, 3'd0, 16'hFFF7));
        send_request(MODE_READ_REG, 16'hFFF8, 32'hFFFF_FFFF);
        repeat (9) exec_step();
        send_request(MODE_READ_MEM, 16'h7FFD, 32'h0);
        send_request(MODE_READ_REG, 16'h5554, 32'h0);
        send_request(MODE_READ_MEM, 16'hFFFF, 32'h0);

        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            quiet_stretch = (n >= 400 && n < 600);
            pick = $urandom_range(99);
            if (pick < 55) begin
                random_exec();
            end else if (pick < 70) begin
                load_word(16'($urandom), $urandom);
            end else if (pick < 85) begin
                send_request(MODE_READ_MEM,
                             written_list[$urandom_range(written_list.size() - 1)],
                             $urandom);
            end else begin
                send_request(MODE_READ_REG, 16'($urandom), $urandom);
            end
        end
        quiet_stretch = 1'b0;

        load_word(model_pc, {7'($urandom), OP_HALT, 22'($urandom)});
        repeat (3) exec_step();
        load_word(16'($urandom), $urandom);
        send_request(MODE_READ_MEM, written_list[written_list.size() - 1], $urandom);
        send_request(MODE_READ_REG, 16'($urandom), $urandom);
        req_valid <= 1'b0;

        while (outstanding != 0) begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
